[hdl/boundary_tag_heap_allocator_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the boundary tag heap allocator
// Clocked on i_clk, switched off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define BTH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bth_pkg.sv]
// ----------------------------------------------------------------------------
// bth_pkg
// Shared types and constants of the boundary tag heap allocator.
// ----------------------------------------------------------------------------
package bth_pkg;

    // default heap size in words
    localparam int unsigned DEF_HEAP_WORDS = 65536;

    // command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // request payload
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] alloc_words;
        logic [15:0] block_addr;
    } t_request;

    // result payload
    typedef struct packed {
        logic [15:0] result_addr;
        logic        status;
        logic [15:0] largest_block;
    } t_result;

endpackage

[hdl/bth_tag_ram.sv]
// ----------------------------------------------------------------------------
// bth_tag_ram
// Single-port tag store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bth_tag_ram #(
    parameter int unsigned DEPTH = bth_pkg::DEF_HEAP_WORDS,
    parameter int unsigned AW    = $clog2(DEPTH),
    parameter int unsigned TW    = AW + 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [TW-1:0] i_wdata,
    output logic [TW-1:0] o_rdata
);

    logic [TW-1:0] r_mem [DEPTH];
    logic [TW-1:0] r_rdata;

    // write or read, one port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/boundary_tag_heap_allocator_top.sv]
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_top
// First-fit heap allocator keeping boundary tags in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   A request (allocate, free, query) is taken when start is high and busy
//   is low. Exactly one result follows, shown on o_result for one cycle
//   with o_result_valid high; it must be taken in that cycle.
// Walk:
//   The walk reads one block header per cycle. After it come 2 tag writes
//   for an allocate that fits (4 when it splits a block), or 1 neighbour
//   read and 2 writes for a valid free, with busy high throughout. A query,
//   a failed allocate or an ignored free writes nothing. The result strobe
//   comes in the cycle after the last of these, with busy already low, so
//   the next request may be taken in the strobe cycle. An unused command
//   code answers zeros in the cycle right after acceptance and never sets
//   busy.
// Reset:
//   i_rst_n is synchronous, active low. After release the block writes the
//   prologue, free block and epilogue tags, with busy high. The rest of the
//   memory is never read before it is written.
// Stalls:
//   The receiver cannot stall; results are not held.
// ----------------------------------------------------------------------------
`include "boundary_tag_heap_allocator_top_assert.svh"

module boundary_tag_heap_allocator_top #(
    parameter int unsigned HEAP_WORDS = bth_pkg::DEF_HEAP_WORDS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bth_pkg::t_request i_request,
    output logic              o_result_valid,
    output bth_pkg::t_result  o_result
);

    localparam int unsigned AW = $clog2(HEAP_WORDS);
    localparam int unsigned TW = AW + 1;
    localparam int unsigned NW = (AW > 17) ? AW : 17;
    localparam logic [AW:0] HW = (AW+1)'(HEAP_WORDS);

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_WALK  = 5'b00100,
        S_NEXT  = 5'b01000,
        S_WRITE = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [2:0]       r_cnt, n_cnt;
    logic [1:0]       r_cmd, n_cmd;
    logic [16:0]      r_need, n_need;
    logic [15:0]      r_target, n_target;
    logic [AW-1:0]    r_p, n_p;
    logic [AW-1:0]    r_last, n_last;
    logic [TW-1:0]    r_last_tag, n_last_tag;
    logic [AW-1:0]    r_best, n_best;
    logic [AW-1:0]    r_size, n_size;
    logic             r_next_ok, n_next_ok;
    logic [AW:0]      r_wa [4];
    logic [AW:0]      n_wa [4];
    logic [TW-1:0]    r_wd [4];
    logic [TW-1:0]    n_wd [4];
    logic [1:0]       r_widx, n_widx;
    logic [1:0]       r_wlast, n_wlast;
    bth_pkg::t_result r_res, n_res;
    logic             r_valid, n_valid;

    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [TW-1:0]    mem_wdata;
    logic [TW-1:0]    mem_rdata;

    // walk decode
    logic [AW-1:0]    t_s;
    logic             t_used;
    logic [AW:0]      nsum;
    logic [AW-1:0]    need_aw;
    logic [AW-1:0]    rem;
    logic [AW-1:0]    best_upd;
    // merge decode
    logic [TW-1:0]    nt;
    logic             next_free;
    logic             prev_free;
    logic [AW:0]      tot;
    logic [AW-1:0]    mp;

    bth_tag_ram #(
        .DEPTH (HEAP_WORDS),
        .AW    (AW),
        .TW    (TW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign t_s      = mem_rdata[TW-1:1];
    assign t_used   = mem_rdata[0];
    assign nsum     = {1'b0, r_p} + {1'b0, t_s};
    assign need_aw  = AW'(r_need);
    assign rem      = t_s - need_aw;
    assign best_upd = (r_cmd == bth_pkg::CMD_QUERY && !t_used && t_s > r_best) ? t_s : r_best;

    assign nt        = r_next_ok ? mem_rdata : '0;
    assign next_free = !nt[0] && (nt[TW-1:1] != '0);
    assign prev_free = !r_last_tag[0];
    assign tot       = {1'b0, r_size}
                     + (next_free ? {1'b0, nt[TW-1:1]} : '0)
                     + (prev_free ? {1'b0, r_last_tag[TW-1:1]} : '0);
    assign mp        = prev_free ? r_last : r_p;

    // control and memory access
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_cmd      = r_cmd;
        n_need     = r_need;
        n_target   = r_target;
        n_p        = r_p;
        n_last     = r_last;
        n_last_tag = r_last_tag;
        n_best     = r_best;
        n_size     = r_size;
        n_next_ok  = r_next_ok;
        n_wa       = r_wa;
        n_wd       = r_wd;
        n_widx     = r_widx;
        n_wlast    = r_wlast;
        n_res      = r_res;
        n_valid    = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = '0;
        mem_wdata  = '0;

        unique case (r_state)
            // initial heap layout
            S_INIT: begin
                mem_we = 1'b1;
                unique case (r_cnt)
                    3'd0: begin
                        mem_addr  = AW'(0);
                        mem_wdata = {AW'(2), 1'b1};
                    end
                    3'd1: begin
                        mem_addr  = AW'(1);
                        mem_wdata = {AW'(2), 1'b1};
                    end
                    3'd2: begin
                        mem_addr  = AW'(2);
                        mem_wdata = {AW'(HEAP_WORDS - 3), 1'b0};
                    end
                    3'd3: begin
                        mem_addr  = AW'(HEAP_WORDS - 2);
                        mem_wdata = {AW'(HEAP_WORDS - 3), 1'b0};
                    end
                    default: begin
                        mem_addr  = AW'(HEAP_WORDS - 1);
                        mem_wdata = {AW'(0), 1'b1};
                    end
                endcase
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    n_state = S_IDLE;
                end
            end

            // take a request, read the prologue header
            S_IDLE: begin
                if (start) begin
                    n_cmd      = i_request.cmd;
                    n_need     = ((i_request.alloc_words == '0) ? 17'd1
                                  : {1'b0, i_request.alloc_words}) + 17'd2;
                    n_target   = i_request.block_addr;
                    n_res      = '0;
                    n_p        = AW'(1);
                    n_last     = '0;
                    n_last_tag = '0;
                    n_best     = '0;
                    mem_addr   = '0;
                    if (i_request.cmd == bth_pkg::CMD_ALLOC || i_request.cmd == bth_pkg::CMD_FREE
                        || i_request.cmd == bth_pkg::CMD_QUERY) begin
                        n_state = S_WALK;
                    end else begin
                        n_valid = 1'b1;
                    end
                end
            end

            // one block header per cycle
            S_WALK: begin
                if (t_s < AW'(2)) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_res.status        = (r_cmd == bth_pkg::CMD_ALLOC);
                    n_res.largest_block = (r_cmd == bth_pkg::CMD_QUERY) ? 16'(r_best) : '0;
                end else if (r_cmd == bth_pkg::CMD_ALLOC && !t_used
                             && NW'(r_need) <= NW'(t_s)) begin
                    n_res.result_addr = 16'(r_p);
                    n_wa[0]  = {1'b0, r_p} - (AW+1)'(1);
                    n_wd[0]  = {(rem >= AW'(3)) ? need_aw : t_s, 1'b1};
                    n_widx   = '0;
                    n_state  = S_WRITE;
                    if (rem >= AW'(3)) begin
                        n_wa[1] = {1'b0, r_p} + {1'b0, need_aw} - (AW+1)'(2);
                        n_wd[1] = {need_aw, 1'b1};
                        n_wa[2] = {1'b0, r_p} + {1'b0, need_aw} - (AW+1)'(1);
                        n_wd[2] = {rem, 1'b0};
                        n_wa[3] = nsum - (AW+1)'(2);
                        n_wd[3] = {rem, 1'b0};
                        n_wlast = 2'd3;
                    end else begin
                        n_wa[1] = nsum - (AW+1)'(2);
                        n_wd[1] = {t_s, 1'b1};
                        n_wlast = 2'd1;
                    end
                end else if (r_cmd == bth_pkg::CMD_FREE && NW'(r_p) == NW'(r_target)) begin
                    if (t_used && r_p != AW'(1)) begin
                        n_size  = t_s;
                        n_state = S_NEXT;
                        if ((nsum - (AW+1)'(1)) < HW) begin
                            mem_addr  = AW'(nsum - (AW+1)'(1));
                            n_next_ok = 1'b1;
                        end else begin
                            n_next_ok = 1'b0;
                        end
                    end else begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                    end
                end else begin
                    n_best     = best_upd;
                    n_last     = r_p;
                    n_last_tag = mem_rdata;
                    if (nsum >= HW) begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                        n_res.status        = (r_cmd == bth_pkg::CMD_ALLOC);
                        n_res.largest_block = (r_cmd == bth_pkg::CMD_QUERY)
                                              ? 16'(best_upd) : '0;
                    end else begin
                        mem_addr = AW'(nsum - (AW+1)'(1));
                        n_p      = nsum[AW-1:0];
                    end
                end
            end

            // merge with free neighbours
            S_NEXT: begin
                n_wa[0] = {1'b0, mp} - (AW+1)'(1);
                n_wd[0] = {tot[AW-1:0], 1'b0};
                n_wa[1] = {1'b0, mp} + tot - (AW+1)'(2);
                n_wd[1] = {tot[AW-1:0], 1'b0};
                n_wlast = 2'd1;
                n_widx  = '0;
                n_state = S_WRITE;
            end

            // write back tags
            S_WRITE: begin
                mem_we    = (r_wa[r_widx] < HW);
                mem_addr  = r_wa[r_widx][AW-1:0];
                mem_wdata = r_wd[r_widx];
                if (r_widx == r_wlast) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end else begin
                    n_widx = r_widx + 2'd1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    // walk and payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_need     <= n_need;
        r_target   <= n_target;
        r_p        <= n_p;
        r_last     <= n_last;
        r_last_tag <= n_last_tag;
        r_best     <= n_best;
        r_size     <= n_size;
        r_next_ok  <= n_next_ok;
        r_wa       <= n_wa;
        r_wd       <= n_wd;
        r_widx     <= n_widx;
        r_wlast    <= n_wlast;
        r_res      <= n_res;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_result       = r_res;

    `BTH_ASSERT_IMP(a_strobe_idle, r_valid, r_state == S_IDLE, "result strobe outside idle")
    `BTH_ASSERT_NXT(a_accept_busy, start && !busy && (i_request.cmd == bth_pkg::CMD_ALLOC || i_request.cmd == bth_pkg::CMD_FREE || i_request.cmd == bth_pkg::CMD_QUERY), busy, "request taken but not busy")
    `BTH_ASSERT_IMP(a_write_phase, mem_we, r_state == S_INIT || r_state == S_WRITE, "tag write outside write phase")
    `BTH_ASSERT_IMP(a_fail_zero, r_valid && r_res.status, r_res.result_addr == '0, "failed allocate with address")

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the boundary tag heap allocator. Requests are sent
// in bursts with random gaps, a tag-level model of the heap predicts every
// result, and each strobed result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned HEAP       = bth_pkg::DEF_HEAP_WORDS;
    localparam logic [1:0]  CMD_SPARE  = 2'd3;
    localparam int unsigned IDLE_LIMIT = 400000;
    localparam int unsigned N_RANDOM   = 1530;
    localparam int unsigned MAX_LIVE   = 40;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    bth_pkg::t_request i_request;
    logic              o_result_valid;
    bth_pkg::t_result  o_result;

    // model of the tag memory and the blocks currently held
    logic [17:0]       heap_tags [HEAP];
    int unsigned       live_blocks [$];
    bth_pkg::t_result  pending_results [$];
    int unsigned       n_errors;
    int unsigned       quiet_cycles;
    int unsigned       burst_left;
    logic              accepted;

    boundary_tag_heap_allocator_top #(.HEAP_WORDS(HEAP)) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_request      (i_request),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- heap model ----------------
    function automatic int unsigned tag_rd(int unsigned a);
        return (a < HEAP) ? int'(heap_tags[a]) : 0;
    endfunction

    function automatic void tag_wr(int unsigned a, int unsigned v);
        if (a < HEAP)
            heap_tags[a] = v[17:0];
    endfunction

    function automatic void put_block(int unsigned p, int unsigned size, bit used);
        tag_wr(p - 1, (size << 1) | used);
        tag_wr(p + size - 2, (size << 1) | used);
    endfunction

    function automatic void heap_init();
        foreach (heap_tags[i])
            heap_tags[i] = '0;
        tag_wr(0, (2 << 1) | 1);
        tag_wr(1, (2 << 1) | 1);
        tag_wr(2, (HEAP - 3) << 1);
        tag_wr(HEAP - 2, (HEAP - 3) << 1);
        tag_wr(HEAP - 1, 1);
    endfunction

    // 0: first fit for need; 1: locate need, previous payload out; 2: largest free
    function automatic int unsigned heap_walk(int mode, int unsigned need,
                                              output int unsigned prev);
        int unsigned p, last, best, n, t, s;
        bit          used;
        p = 1; last = 0; best = 0; n = 0; prev = 0;
        while (n < HEAP) begin
            n++;
            t    = tag_rd(p - 1);
            s    = t >> 1;
            used = t[0];
            if (s < 2)
                break;
            if (mode == 0 && !used && need <= s)
                return p;
            if (mode == 1 && p == need) begin
                prev = last;
                return (used && p != 1) ? p : 0;
            end
            if (mode == 2 && !used && s > best)
                best = s;
            last = p;
            p += s;
            if (p >= HEAP)
                break;
        end
        return best;
    endfunction

    function automatic bth_pkg::t_result predict_result(bth_pkg::t_request rq);
        bth_pkg::t_result r;
        int unsigned      words, need, p, csize, prev, size, nt, pt;
        bit               prev_free, next_free;
        r = '0;
        case (rq.cmd)
            bth_pkg::CMD_ALLOC: begin
                words = (rq.alloc_words == 0) ? 1 : rq.alloc_words;
                need  = words + 2;
                p     = heap_walk(0, need, prev);
                if (p == 0) begin
                    r.status = 1'b1;
                end else begin
                    csize = tag_rd(p - 1) >> 1;
                    if (csize - need >= 3) begin
                        put_block(p, need, 1'b1);
                        put_block(p + need, csize - need, 1'b0);
                    end else begin
                        put_block(p, csize, 1'b1);
                    end
                    r.result_addr = p[15:0];
                end
            end
            bth_pkg::CMD_FREE: begin
                p = heap_walk(1, rq.block_addr, prev);
                if (p != 0 && prev != 0) begin
                    size      = tag_rd(p - 1) >> 1;
                    nt        = tag_rd(p + size - 1);
                    pt        = tag_rd(prev - 1);
                    prev_free = !pt[0];
                    next_free = !nt[0] && (nt >> 1) != 0;
                    if (next_free)
                        size += nt >> 1;
                    if (prev_free) begin
                        size += pt >> 1;
                        p = prev;
                    end
                    put_block(p, size, 1'b0);
                end
            end
            bth_pkg::CMD_QUERY: r.largest_block = 16'(heap_walk(2, 0, prev));
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- request driver ----------------
    // called just after a rising edge; returns at the edge that takes the request, or after the gap that ends a burst
    task automatic send_request(bth_pkg::t_request rq);
        bth_pkg::t_result exp_r;
        start     <= 1'b1;
        i_request <= rq;
        forever begin
            @(negedge i_clk);
            if (!busy) begin
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
        exp_r = predict_result(rq);
        pending_results.push_back(exp_r);
        if (rq.cmd == bth_pkg::CMD_ALLOC && exp_r.status == 1'b0)
            live_blocks.push_back(exp_r.result_addr);
        if (rq.cmd == bth_pkg::CMD_FREE)
            foreach (live_blocks[i])
                if (live_blocks[i] == rq.block_addr) begin
                    live_blocks.delete(i);
                    break;
                end
        // bursts with random gaps between them
        if (burst_left == 0) begin
            start      <= 1'b0;
            burst_left  = $urandom_range(1, 30);
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_alloc(int unsigned words);
        bth_pkg::t_request rq;
        rq             = '0;
        rq.cmd         = bth_pkg::CMD_ALLOC;
        rq.alloc_words = words[15:0];
        rq.block_addr  = 16'($urandom);
        send_request(rq);
    endtask

    task automatic send_free(int unsigned addr);
        bth_pkg::t_request rq;
        rq             = '0;
        rq.cmd         = bth_pkg::CMD_FREE;
        rq.alloc_words = 16'($urandom);
        rq.block_addr  = addr[15:0];
        send_request(rq);
    endtask

    task automatic send_other(logic [1:0] cmd);
        bth_pkg::t_request rq;
        rq             = '0;
        rq.cmd         = cmd;
        rq.alloc_words = 16'($urandom);
        rq.block_addr  = 16'($urandom);
        send_request(rq);
    endtask

    // ---------------- result checking ----------------
    always @(negedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result addr=%0d status=%0b largest=%0d",
                         $time, o_result.result_addr, o_result.status,
                         o_result.largest_block);
                n_errors++;
            end else begin
                bth_pkg::t_result e;
                e = pending_results.pop_front();
                if (o_result.result_addr !== e.result_addr) begin
                    $display("%0t: result_addr exp %0d got %0d", $time,
                             e.result_addr, o_result.result_addr);
                    n_errors++;
                end
                if (o_result.status !== e.status) begin
                    $display("%0t: status exp %0b got %0b", $time, e.status,
                             o_result.status);
                    n_errors++;
                end
                if (o_result.largest_block !== e.largest_block) begin
                    $display("%0t: largest_block exp %0d got %0d", $time,
                             e.largest_block, o_result.largest_block);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no request taken and no result
    always @(posedge i_clk) begin
        accepted = start && !busy;
        if (!i_rst_n || accepted || o_result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_reset_query();
        send_other(bth_pkg::CMD_QUERY);
    endtask

    // whole heap in one block, then no fit, then release
    task automatic test_extremes();
        send_alloc(65531);
        send_alloc(1);
        send_other(bth_pkg::CMD_QUERY);
        send_free(live_blocks[0]);
        send_alloc(65535);
        send_alloc(65532);
        send_other(bth_pkg::CMD_QUERY);
    endtask

    // free with no, next, previous and both neighbours free
    task automatic test_merges();
        int unsigned a, b, c, d;
        send_alloc(4); a = live_blocks[$];
        send_alloc(4); b = live_blocks[$];
        send_alloc(4); c = live_blocks[$];
        send_alloc(4); d = live_blocks[$];
        send_free(b);
        send_free(a);
        send_free(c);
        send_other(bth_pkg::CMD_QUERY);
        send_free(d);
        send_other(bth_pkg::CMD_QUERY);
    endtask

    // zero request, bad frees, spare command code, double free
    task automatic test_odd_requests();
        int unsigned a;
        send_alloc(0);
        a = live_blocks[$];
        send_free(1);
        send_free(0);
        send_free(a + 1);
        send_free(65535);
        send_other(CMD_SPARE);
        send_free(a);
        send_free(a);
    endtask

    task automatic test_random();
        int unsigned sel, words;
        repeat (N_RANDOM) begin
            sel = $urandom_range(0, 99);
            if (live_blocks.size() > MAX_LIVE && sel < 50)
                sel = 60;
            if (sel < 50) begin
                case ($urandom_range(0, 19))
                    0:       words = $urandom_range(0, 65535);
                    1, 2:    words = $urandom_range(33, 4000);
                    default: words = $urandom_range(0, 32);
                endcase
                send_alloc(words);
            end else if (sel < 85 && live_blocks.size() != 0) begin
                send_free(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
            end else if (sel < 92) begin
                send_other(bth_pkg::CMD_QUERY);
            end else if (sel < 98) begin
                send_free($urandom_range(0, 65535));
            end else begin
                send_other(CMD_SPARE);
            end
        end
    endtask

    initial begin
        n_errors     = 0;
        quiet_cycles = 0;
        burst_left   = 0;
        start        = 1'b0;
        i_request    = '0;
        i_rst_n      = 1'b0;
        heap_init();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_query();
        test_extremes();
        test_merges();
        test_odd_requests();
        test_random();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

[sim.f]
+incdir+hdl
hdl/bth_pkg.sv
hdl/bth_tag_ram.sv
hdl/boundary_tag_heap_allocator_top.sv
tb/sv/tb_top.sv
